// ===== rtl/chrl_pkg.sv =====
// Shared types, codes and defaults for the consistent-hash ring lookup block.
package chrl_pkg;

    localparam int DEF_RING_POINTS = 64;
    localparam int DEF_NODE_BITS   = 8;

    localparam int HASH_W = 64;
    localparam int NODE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic finish;
    } chrl_cmd_t;

    typedef struct packed {
        logic skip;
        logic scan_last;
        logic out_free;
    } chrl_sts_t;

endpackage

// ===== rtl/chrl_ctrl.sv =====
// Sequencing state machine for the ring lookup block.
module chrl_ctrl
    import chrl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  chrl_sts_t sts,
    output chrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.skip ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg != S_IDLE))
        else $error("start did not leave idle");

    a_drain_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=> (state_reg == S_FINISH))
        else $error("drain not followed by finish");

    a_finish_only_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (state_reg == S_FINISH))
        else $error("finish issued outside the final step");

endmodule

// ===== rtl/chrl_dpath.sv =====
// Point table memory, scan accumulators and result register of the ring lookup.
module chrl_dpath
    import chrl_pkg::*;
#(
    parameter int RING_POINTS = DEF_RING_POINTS,
    parameter int NODE_BITS   = DEF_NODE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [OP_W-1:0]   operation,
    input  logic [HASH_W-1:0] point_hash,
    input  logic [NODE_W-1:0] node_index,
    input  logic [HASH_W-1:0] lookup_key,
    input  chrl_cmd_t         cmd,
    output chrl_sts_t         sts,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NODE_W-1:0] owner_node,
    output logic [ST_W-1:0]   status
);

    localparam int IDX_W = (RING_POINTS > 1) ? $clog2(RING_POINTS) : 1;
    localparam int CNT_W = $clog2(RING_POINTS + 1);
    localparam int OWN_W = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;

    logic [HASH_W-1:0] hash_mem [RING_POINTS];
    logic [OWN_W-1:0]  own_mem  [RING_POINTS];

    logic [OP_W-1:0]   op_reg;
    logic [HASH_W-1:0] ph_reg;
    logic [OWN_W-1:0]  node_reg;
    logic [HASH_W-1:0] key_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              d_vld_reg;
    logic [IDX_W-1:0]  d_idx_reg;
    logic [HASH_W-1:0] rd_hash_reg;
    logic [OWN_W-1:0]  rd_own_reg;

    logic              first_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  eq_idx_reg;
    logic              have_ge_reg;
    logic [HASH_W-1:0] best_ge_reg;
    logic [OWN_W-1:0]  own_ge_reg;
    logic [HASH_W-1:0] best_min_reg;
    logic [OWN_W-1:0]  own_min_reg;

    logic              out_valid_reg;
    logic [NODE_W-1:0] owner_reg;
    logic [ST_W-1:0]   status_reg;

    logic              is_insert;
    logic              is_lookup;
    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              take_min;
    logic              take_ge;
    logic              hit_eq;
    logic [NODE_W-1:0] res_owner;
    logic [ST_W-1:0]   res_status;

    assign is_insert = (op_reg == OP_INSERT);
    assign is_lookup = (op_reg == OP_LOOKUP);
    assign full      = (cnt_reg == CNT_W'(RING_POINTS));

    assign sts.skip      = ((operation != OP_INSERT) && (operation != OP_LOOKUP))
                           || (cnt_reg == '0);
    assign sts.scan_last = (rd_idx_reg == (cnt_reg - CNT_W'(1)));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign take_min = first_reg || (rd_hash_reg < best_min_reg);
    assign take_ge  = (rd_hash_reg >= key_reg) && (!have_ge_reg || (rd_hash_reg < best_ge_reg));
    assign hit_eq   = (rd_hash_reg == ph_reg);

    assign wr_en   = cmd.finish && is_insert && (found_reg || !full);
    assign wr_addr = found_reg ? eq_idx_reg : cnt_reg[IDX_W-1:0];

    always_comb
    begin
        cnt_next   = cnt_reg;
        res_owner  = '0;
        res_status = ST_OK;
        unique case (op_reg)
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            OP_INSERT:
            begin
                if (!found_reg)
                begin
                    if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            OP_LOOKUP:
            begin
                if (cnt_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_owner = NODE_W'(have_ge_reg ? own_ge_reg : own_min_reg);
                end
            end
            OP_NONE:
            begin
                res_status = ST_OK;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hash_mem[wr_addr] <= ph_reg;
            own_mem[wr_addr]  <= node_reg;
        end
        if (cmd.rd_en)
        begin
            rd_hash_reg <= hash_mem[rd_idx_reg[IDX_W-1:0]];
            rd_own_reg  <= own_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= operation;
            ph_reg   <= point_hash;
            node_reg <= node_index[OWN_W-1:0];
            key_reg  <= lookup_key;
        end
        d_idx_reg <= rd_idx_reg[IDX_W-1:0];
        if (d_vld_reg)
        begin
            if (take_min)
            begin
                best_min_reg <= rd_hash_reg;
                own_min_reg  <= rd_own_reg;
            end
            if (take_ge)
            begin
                best_ge_reg <= rd_hash_reg;
                own_ge_reg  <= rd_own_reg;
            end
            if (hit_eq)
            begin
                eq_idx_reg <= d_idx_reg;
            end
        end
        if (cmd.finish)
        begin
            owner_reg  <= res_owner;
            status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            d_vld_reg     <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            have_ge_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= cmd.rd_en;
            if (cmd.start)
            begin
                rd_idx_reg  <= '0;
                first_reg   <= 1'b1;
                found_reg   <= 1'b0;
                have_ge_reg <= 1'b0;
            end
            else if (cmd.rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (d_vld_reg)
            begin
                first_reg <= 1'b0;
                if (take_ge)
                begin
                    have_ge_reg <= 1'b1;
                end
                if (hit_eq)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign owner_node = owner_reg;
    assign status     = status_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RING_POINTS))
        else $error("point count above table size");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_idx_reg < cnt_reg))
        else $error("scan read beyond stored points");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting word");

endmodule

// ===== rtl/consistent_hash_ring_lookup.sv =====
// Top level of the consistent-hash ring lookup block.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+--------------------------------------------
//   input   | in        | in_valid, in_stall | operation, point_hash, node_index, lookup_key
//   output  | out       | out_valid, out_stall | owner_node, status
//
// Clear, the unused code, and any operation on an empty table skip the scan and go straight to the final step.
// Insert and lookup scan the stored points through the single table read port,
// one point per cycle, reading every point currently stored.
// A finished result waits in the output register while the next word is accepted.
// Reset zeroes the point count and the control flags, not the table; the table needs no clearing pass.
// A stalled output holds the block in its final step until the register frees.
module consistent_hash_ring_lookup
    import chrl_pkg::*;
#(
    parameter int RING_POINTS = DEF_RING_POINTS,
    parameter int NODE_BITS   = DEF_NODE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [HASH_W-1:0] point_hash,
    input  logic [NODE_W-1:0] node_index,
    input  logic [HASH_W-1:0] lookup_key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NODE_W-1:0] owner_node,
    output logic [ST_W-1:0]   status
);

    chrl_cmd_t cmd;
    chrl_sts_t sts;

    chrl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    chrl_dpath #(
        .RING_POINTS (RING_POINTS),
        .NODE_BITS   (NODE_BITS)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .point_hash (point_hash),
        .node_index (node_index),
        .lookup_key (lookup_key),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .owner_node (owner_node),
        .status     (status)
    );

endmodule

// ===== bench/ring_owner_checker.sv =====
// Checker for the consistent-hash ring lookup block: predicts each result word and compares it.
module ring_owner_checker
    import chrl_pkg::*;
#(
    parameter int RING_POINTS = DEF_RING_POINTS,
    parameter int NODE_BITS   = DEF_NODE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [HASH_W-1:0] point_hash,
    input  logic [NODE_W-1:0] node_index,
    input  logic [HASH_W-1:0] lookup_key,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [NODE_W-1:0] owner_node,
    input  logic [ST_W-1:0]   status,
    output int unsigned       mismatches,
    output int unsigned       owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [NODE_W-1:0] NODE_MASK = NODE_W'((1 << NODE_BITS) - 1);

    typedef struct packed {
        logic [NODE_W-1:0] owner;
        logic [ST_W-1:0]   code;
    } ring_answer_t;

    logic [HASH_W-1:0] ring_pos  [RING_POINTS];
    logic [NODE_W-1:0] ring_node [RING_POINTS];
    int unsigned       ring_used = 0;
    ring_answer_t      owed_answers [$];

    function automatic ring_answer_t ring_apply(input logic [OP_W-1:0] op,
                                                input logic [HASH_W-1:0] pos,
                                                input logic [NODE_W-1:0] node,
                                                input logic [HASH_W-1:0] key);
        ring_answer_t      r;
        int                slot;
        bit                have_ge;
        logic [HASH_W-1:0] best_ge;
        logic [HASH_W-1:0] best_min;
        logic [NODE_W-1:0] own_ge;
        logic [NODE_W-1:0] own_min;
        r.owner = '0;
        r.code = ST_OK;
        case (op)
            OP_CLEAR:
            begin
                ring_used = 0;
            end
            OP_INSERT:
            begin
                slot = -1;
                for (int i = 0; i < ring_used; i++)
                begin
                    if (slot < 0 && ring_pos[i] == pos)
                        slot = i;
                end
                if (slot >= 0)
                    ring_node[slot] = node & NODE_MASK;
                else if (ring_used < RING_POINTS)
                begin
                    ring_pos[ring_used] = pos;
                    ring_node[ring_used] = node & NODE_MASK;
                    ring_used++;
                end
                else
                    r.code = ST_FULL;
            end
            OP_LOOKUP:
            begin
                if (ring_used == 0)
                    r.code = ST_EMPTY;
                else
                begin
                    have_ge = 1'b0;
                    best_ge = '0;
                    best_min = '0;
                    own_ge = '0;
                    own_min = '0;
                    for (int i = 0; i < ring_used; i++)
                    begin
                        if (i == 0 || ring_pos[i] < best_min)
                        begin
                            best_min = ring_pos[i];
                            own_min = ring_node[i];
                        end
                        if (ring_pos[i] >= key && (!have_ge || ring_pos[i] < best_ge))
                        begin
                            have_ge = 1'b1;
                            best_ge = ring_pos[i];
                            own_ge = ring_node[i];
                        end
                    end
                    r.owner = have_ge ? own_ge : own_min;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        ring_answer_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ring_owner_checker: unexpected word: owner %0d status %0d",
                                 owner_node, status);
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (owner_node !== want.owner || status !== want.code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ring_owner_checker: mismatch: owner exp %0d got %0d, ",
                                      "status exp %0d got %0d"},
                                     want.owner, owner_node, want.code, status);
                    end
                end
            end
            if (in_valid && !in_stall)
                owed_answers.push_back(ring_apply(operation, point_hash, node_index,
                                                  lookup_key));
            owed = owed_answers.size();
        end
    end

endmodule

// ===== bench/tb_consistent_hash_ring_lookup.sv =====
// Testbench top for the consistent-hash ring lookup block: reset, stimulus, idling and verdict.
module tb_consistent_hash_ring_lookup;
    import chrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 2;
    localparam int RANDOM_WORDS = 1300;
    localparam int LIMIT_NS     = 3_000_000;
    localparam int MAX_POINTS   = DEF_RING_POINTS;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   operation  = OP_NONE;
    logic [HASH_W-1:0] point_hash = '0;
    logic [NODE_W-1:0] node_index = '0;
    logic [HASH_W-1:0] lookup_key = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [NODE_W-1:0] owner_node;
    logic [ST_W-1:0]   status;

    int unsigned       mismatches;
    int unsigned       owed;
    int unsigned       words_taken = 0;
    int unsigned       words_sent  = 0;
    int unsigned       burst_left  = 0;
    int unsigned       stall_left  = 0;
    int unsigned       stall_mode  = 0;
    logic [HASH_W-1:0] sent_points [$];

    always #(CLK_HALF) clk = ~clk;

    consistent_hash_ring_lookup dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .point_hash (point_hash),
        .node_index (node_index),
        .lookup_key (lookup_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .owner_node (owner_node),
        .status     (status)
    );

    ring_owner_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .point_hash (point_hash),
        .node_index (node_index),
        .lookup_key (lookup_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .owner_node (owner_node),
        .status     (status),
        .mismatches (mismatches),
        .owed       (owed)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            words_taken <= words_taken + 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 400);
            end
            else
                stall_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((stall_left % 32) < 20);
            endcase
        end
    end

    function automatic logic [HASH_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HASH_W-1:0] pick_key();
        logic [HASH_W-1:0] base;
        if (sent_points.size() == 0)
            return rand64();
        base = sent_points[$urandom_range(0, sent_points.size() - 1)];
        case ($urandom_range(0, 5))
            0: return base;
            1: return base + 1;
            2: return base - 1;
            3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return rand64();
        endcase
    endfunction

    function automatic bit point_known(input logic [HASH_W-1:0] pos);
        foreach (sent_points[i])
        begin
            if (sent_points[i] == pos)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [HASH_W-1:0] pos,
                             input logic [NODE_W-1:0] node, input logic [HASH_W-1:0] key);
        int unsigned target;
        int unsigned gap;
        target = words_taken + 1;
        in_valid <= 1'b1;
        operation <= op;
        point_hash <= pos;
        node_index <= node;
        lookup_key <= key;
        do
            @(negedge clk);
        while (words_taken != target);
        words_sent++;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        else
            burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic put_point(input logic [HASH_W-1:0] pos, input logic [NODE_W-1:0] node);
        if (!point_known(pos) && sent_points.size() < MAX_POINTS)
            sent_points.push_back(pos);
        send_word(OP_INSERT, pos, node, rand64());
    endtask

    task automatic seek_owner(input logic [HASH_W-1:0] key);
        send_word(OP_LOOKUP, rand64(), NODE_W'($urandom), key);
    endtask

    task automatic wipe_ring();
        sent_points.delete();
        send_word(OP_CLEAR, rand64(), NODE_W'($urandom), rand64());
    endtask

    function automatic logic [HASH_W-1:0] fresh_point();
        if (sent_points.size() != 0 && $urandom_range(0, 7) == 0)
            return sent_points[$urandom_range(0, sent_points.size() - 1)];
        if ($urandom_range(0, 3) == 0)
            return {rand64() & 64'hFFFF_FFFF_FFFF_FF00} | 64'(($urandom_range(0, 15)));
        return rand64();
    endfunction

    task automatic fill_session();
        int unsigned extra;
        wipe_ring();
        extra = $urandom_range(2, 10);
        while (sent_points.size() < MAX_POINTS || extra > 0)
        begin
            if (sent_points.size() >= MAX_POINTS)
                extra--;
            if ($urandom_range(0, 4) == 0)
                seek_owner(pick_key());
            else
                put_point(fresh_point(), NODE_W'($urandom));
        end
        repeat ($urandom_range(3, 10)) seek_owner(pick_key());
    endtask

    task automatic small_session();
        logic [HASH_W-1:0] cluster;
        wipe_ring();
        cluster = rand64();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 1) != 0)
                put_point(cluster ^ 64'($urandom_range(0, 255)), NODE_W'($urandom));
            else
                put_point(fresh_point(), NODE_W'($urandom));
        end
        repeat ($urandom_range(4, 14))
        begin
            if ($urandom_range(0, 5) == 0)
                put_point(fresh_point(), NODE_W'($urandom));
            else
                seek_owner(pick_key());
        end
    endtask

    task automatic noise_session();
        logic [OP_W-1:0] op;
        repeat ($urandom_range(3, 10))
        begin
            op = OP_W'($urandom_range(0, 3));
            case (op)
                OP_CLEAR: wipe_ring();
                OP_INSERT: put_point(rand64(), NODE_W'($urandom));
                OP_LOOKUP: seek_owner(rand64());
                default: send_word(OP_NONE, rand64(), NODE_W'($urandom), rand64());
            endcase
        end
    endtask

    initial
    begin
        int unsigned directed_words;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        seek_owner(rand64());
        send_word(OP_NONE, '0, '0, '0);
        put_point('0, 8'h00);
        put_point('1, 8'hFF);
        seek_owner('0);
        seek_owner('1);
        seek_owner(64'h1);
        put_point('1, 8'h5A);
        seek_owner(64'hFFFF_FFFF_FFFF_FFFE);
        send_word(OP_NONE, '1, '1, '1);
        put_point(64'h8000_0000_0000_0000, 8'h80);
        seek_owner(64'h7FFF_FFFF_FFFF_FFFF);
        seek_owner(64'h8000_0000_0000_0001);
        wipe_ring();
        seek_owner('0);
        put_point(64'h8000_0000_0000_0000, 8'h01);
        seek_owner(64'h8000_0000_0000_0001);
        seek_owner('0);
        wipe_ring();
        seek_owner('1);
        directed_words = words_sent;

        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: fill_session();
                3, 4, 5, 6: small_session();
                7, 8: noise_session();
                default:
                begin
                    wipe_ring();
                    repeat ($urandom_range(1, 4)) seek_owner(rand64());
                end
            endcase
        end

        in_valid <= 1'b0;
        while (owed != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("tb_consistent_hash_ring_lookup: PASS");
        else
            $display("tb_consistent_hash_ring_lookup: FAIL");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("tb_consistent_hash_ring_lookup: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chrl_pkg.sv
rtl/chrl_ctrl.sv
rtl/chrl_dpath.sv
rtl/consistent_hash_ring_lookup.sv
bench/ring_owner_checker.sv
bench/tb_consistent_hash_ring_lookup.sv
